>>> rtl/bounded_ordered_list_engine_core_assert.svh
// assertion macros for the ordered list engine
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define BOL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked at the same edge
`define BOL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BOL_ASSERT(lbl, clk, rst, prop, msg)
`define BOL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/bol_pkg.sv
// shared types and constants for the ordered list engine
// no dependencies
`default_nettype none
package bol_pkg;

  localparam int KEY_W = 32;
  localparam int REC_W = 32;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_SORTED_INS = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_KEY = 3'd5,
    CMD_FETCH_POS  = 3'd6,
    CMD_FETCH_KEY  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } st_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [KEY_W-1:0] key_in;
    logic [REC_W-1:0]        record_in;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic                    success;
    logic signed [KEY_W-1:0] key_out;
    logic [REC_W-1:0]        record_out;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic from_prev;
    logic from_next;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/bounded_ordered_list_engine_core.sv
// top level of the ordered list engine: control, row of cells, result register
// depends on bol_pkg, bol_cell, bol_scan and the assertion macro header
//
//  channel   handshake          payload
//  request   start / busy       request  (command, key_in, record_in, position)
//  result    done (one cycle)   result   (success, key_out, record_out, entry_count, is_empty)
//
// a request runs as compare then apply: the cells compare their keys in parallel, then the
// prefix scan picks the first match and the affected cells shift or load at once
// busy is high only in the compare cycle; a new request is taken during the apply cycle
// done pulses in the cycle after apply
// rst clears control and the count; cell contents are left as they are
// results cannot be held off by the receiver
`default_nettype none
`include "bounded_ordered_list_engine_core_assert.svh"
module bounded_ordered_list_engine_core
  import bol_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int RECORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      done,
  output rsp_t      result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (RECORD_WIDTH < REC_W) ? RECORD_WIDTH : REC_W;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  st_t             state, state_next;
  req_t            req;
  logic [CW-1:0]   count, count_next;
  logic            accept, apply;

  logic signed [KEY_W-1:0] ckey [CAPACITY];
  logic [RW-1:0]           crec [CAPACITY];
  logic [CAPACITY-1:0]     hit, first, after, occupied, pos_match, tail;
  cell_ctl_t               ctl [CAPACITY];
  logic                    any;

  logic                    is_ins, ins_ok, del_ok, success, fetch_ok;
  logic signed [KEY_W-1:0] sel_key;
  logic [RW-1:0]           sel_rec;

  assign busy   = (state == ST_CMP);
  assign accept = start && !busy;
  assign apply  = (state == ST_APPLY);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_CMP;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: state_next = accept ? ST_CMP : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= apply;
      if (apply) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
    if (apply) begin
      result.success     <= success;
      result.key_out     <= fetch_ok ? sel_key : '0;
      result.record_out  <= fetch_ok ? REC_W'(sel_rec) : '0;
      result.entry_count <= CNT_W'(count_next);
      result.is_empty    <= (count_next == '0);
    end
  end

  // row of cells, each passing key and record to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] pkey, nkey;
    logic [RW-1:0]           prec, nrec;

    assign occupied[i]  = (count > CW'(i));
    assign tail[i]      = (count == CW'(i));
    assign pos_match[i] = (PW'(req.position) == PW'(i + 1));

    if (i == 0) begin : g_head
      assign pkey = '0;
      assign prec = '0;
    end else begin : g_body
      assign pkey = ckey[i-1];
      assign prec = crec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nkey = '0;
      assign nrec = '0;
    end else begin : g_inner
      assign nkey = ckey[i+1];
      assign nrec = crec[i+1];
    end

    bol_cell #(
      .RW (RW)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (busy),
      .cmd       (req.command),
      .cmp_key   (req.key_in),
      .head      (i == 0),
      .occupied  (occupied[i]),
      .pos_match (pos_match[i]),
      .ctl       (ctl[i]),
      .new_rec   (req.record_in[RW-1:0]),
      .prev_key  (pkey),
      .prev_rec  (prec),
      .next_key  (nkey),
      .next_rec  (nrec),
      .key       (ckey[i]),
      .rec       (crec[i]),
      .hit       (hit[i])
    );
  end

  bol_scan #(
    .N (CAPACITY)
  ) u_scan (
    .hit   (hit),
    .first (first),
    .after (after),
    .any   (any)
  );

  always_comb begin
    is_ins = (req.command == CMD_PUSH_FRONT) || (req.command == CMD_PUSH_BACK) ||
             (req.command == CMD_SORTED_INS);
    ins_ok = apply && is_ins && (count < CW'(CAPACITY));
    del_ok = apply && any &&
             ((req.command == CMD_POP_FRONT) || (req.command == CMD_REMOVE_KEY));
    fetch_ok = any &&
               ((req.command == CMD_FETCH_POS) || (req.command == CMD_FETCH_KEY));

    unique case (req.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED_INS:
        success = (count < CW'(CAPACITY));
      CMD_POP_BACK:
        success = (count != '0);
      default:
        success = any;
    endcase

    count_next = count;
    if (success) begin
      unique case (req.command) inside
        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED_INS:
          count_next = count + CW'(1);
        CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_KEY:
          count_next = count - CW'(1);
        default:
          count_next = count;
      endcase
    end
  end

  // with no match an insert lands at the tail
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].load      = ins_ok && (first[i] || (tail[i] && !any));
      ctl[i].from_prev = ins_ok && after[i];
      ctl[i].from_next = del_ok && (first[i] || after[i]);
    end
  end

  // and-or select of the first matching cell
  always_comb begin
    sel_key = '0;
    sel_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key = sel_key | (ckey[i] & {KEY_W{first[i]}});
      sel_rec = sel_rec | (crec[i] & {RW{first[i]}});
    end
  end

  `BOL_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count above capacity")
  `BOL_ASSERT_IMP(a_done_after_apply, clk, rst, done, $past(state == ST_APPLY), "stray done")
  `BOL_ASSERT_IMP(a_cmp_after_accept, clk, rst, state == ST_CMP, $past(start && !busy), "compare without request")
  `BOL_ASSERT_IMP(a_one_first, clk, rst, apply, $onehot0(first), "more than one first match")

endmodule
`default_nettype wire

>>> rtl/bol_cell.sv
// one list slot: key and record registers, match flag, neighbour shifting
// depends on bol_pkg
`default_nettype none
module bol_cell
  import bol_pkg::*;
#(
  parameter int RW = 32
) (
  input  wire logic                    clk,
  input  wire logic                    cmp_en,
  input  wire cmd_t                    cmd,
  input  wire logic signed [KEY_W-1:0] cmp_key,
  input  wire logic                    head,
  input  wire logic                    occupied,
  input  wire logic                    pos_match,
  input  wire cell_ctl_t               ctl,
  input  wire logic [RW-1:0]           new_rec,
  input  wire logic signed [KEY_W-1:0] prev_key,
  input  wire logic [RW-1:0]           prev_rec,
  input  wire logic signed [KEY_W-1:0] next_key,
  input  wire logic [RW-1:0]           next_rec,
  output logic signed [KEY_W-1:0]      key,
  output logic [RW-1:0]                rec,
  output logic                         hit
);

  logic hit_next;

  always_comb begin
    unique case (cmd) inside
      CMD_PUSH_FRONT:                hit_next = head;
      CMD_PUSH_BACK, CMD_POP_BACK:   hit_next = 1'b0;
      CMD_SORTED_INS:                hit_next = occupied && !(key < cmp_key);
      CMD_POP_FRONT:                 hit_next = head && occupied;
      CMD_REMOVE_KEY, CMD_FETCH_KEY: hit_next = occupied && (key == cmp_key);
      CMD_FETCH_POS:                 hit_next = occupied && pos_match;
      default:                       hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit <= hit_next;
    end
    if (ctl.load) begin
      key <= cmp_key;
      rec <= new_rec;
    end else if (ctl.from_prev) begin
      key <= prev_key;
      rec <= prev_rec;
    end else if (ctl.from_next) begin
      key <= next_key;
      rec <= next_rec;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bol_scan.sv
// log-depth prefix scan over the cell match flags: first hit and cells after it
// depends on bol_pkg
`default_nettype none
module bol_scan
  import bol_pkg::*;
#(
  parameter int N = 64
) (
  input  wire logic [N-1:0] hit,
  output logic [N-1:0]      first,
  output logic [N-1:0]      after,
  output logic              any
);

  localparam int L = $clog2(N);

  logic [L:0][N-1:0] pre;

  assign pre[0] = hit;

  for (genvar l = 0; l < L; l++) begin : g_lvl
    for (genvar j = 0; j < N; j++) begin : g_bit
      if (j >= (1 << l)) begin : g_or
        assign pre[l+1][j] = pre[l][j] | pre[l][j-(1<<l)];
      end else begin : g_pass
        assign pre[l+1][j] = pre[l][j];
      end
    end
  end

  // after: some earlier cell already matched
  assign after = {pre[L][N-2:0], 1'b0};
  assign first = hit & ~after;
  assign any   = pre[L][N-1];

endmodule
`default_nettype wire
